/* hw/rtl/rdb_pkg.sv */
// Shared types and constants for the RMS dBFS level meter.
package rdb_pkg;

    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned SQ_W     = 48;
    localparam int unsigned LOG_W    = 22;   // 6-bit integer, 16-bit fraction
    localparam int unsigned MANT_W   = 31;   // Q30 mantissa, one guard bit

    // log2(8388607) in Q16, doubled: full-scale reference
    localparam logic [LOG_W:0] FS_LOG2X2_Q16 = 23'(2 * 1507327);
    localparam logic [17:0]    DB_PER_LOG2_Q16 = 18'd197283;
    localparam logic signed [15:0] FLOOR_Q8   = -16'sd23040;
    localparam logic signed [15:0] VU_LOW_Q8  = -16'sd15360;
    localparam logic signed [15:0] VU_HIGH_Q8 = -16'sd2560;

    typedef struct packed {
        logic signed [31:0] sample_word;
        logic               last_in_block;
    } t_sample_req;

    typedef struct packed {
        logic signed [15:0] level_dbfs;
        logic [3:0]         vu_level;
        logic [10:0]        blk_len;
    } t_level_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG_SUM_NORM,
        ST_LOG_SUM_SQ,
        ST_LOG_CNT_NORM,
        ST_LOG_CNT_SQ,
        ST_SCALE,
        ST_LEVEL,
        ST_VU,
        ST_OUT
    } t_state;

endpackage

/* hw/rtl/rdb_if.sv */
// Valid/ready channel interface carrying a generic payload.
interface rdb_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/block_rms_dbfs_level_meter_core.sv */
// RMS dBFS level meter: accumulates squared samples and reports block level.
//
// Each request carries a raw 32-bit I2S word whose top 24 bits are the
// signed audio sample, plus a last_in_block flag. The sample is squared and
// added to a running sum, so an open block takes one request every cycle.
// A block closes on last_in_block or when BLOCK_MAX samples
// have been taken; the core then stops accepting requests and computes the
// level with one shared 31x31 squarer: log2 of the sum (a normalize step
// and then one squaring per fraction bit), log2 of the count (the same),
// the difference, the multiply by 10*log10(2) and the level clamp, the VU
// step and the hand-over. The result (level_dbfs in 1/256 dB clamped to
// -90..0, vu_level 0..10 and blk_len) then moves into an output register
// that holds it until taken, and requests of the next block are accepted
// again at once. Should the previous result still be waiting when the next
// block is done, hold in the hand-over state until it has gone.
module block_rms_dbfs_level_meter_core #(
    parameter int unsigned BLOCK_MAX = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rdb_if.sink   i_in,
    rdb_if.source o_out
);

    localparam int unsigned CNT_W = $clog2(BLOCK_MAX + 1);
    // Room for BLOCK_MAX squares of the largest sample magnitude, 2^46.
    localparam int unsigned SUM_W = rdb_pkg::SQ_W - 2 + CNT_W;

    // Request payload fields.
    logic signed [31:0] w_sample_word;
    logic               w_last_in_block;
    assign w_sample_word   = i_in.payload.sample_word;
    assign w_last_in_block = i_in.payload.last_in_block;

    rdb_pkg::t_state r_state, n_state;

    logic [SUM_W-1:0]           r_sum, n_sum;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [rdb_pkg::MANT_W-1:0] r_x, n_x;        // log mantissa, Q30
    logic [5:0]                 r_p, n_p;        // log integer part
    logic [15:0]                r_frac, n_frac;
    logic [4:0]                 r_step, n_step;
    logic [rdb_pkg::LOG_W-1:0]  r_lsum, n_lsum;  // log2(sum) Q16
    logic [rdb_pkg::LOG_W+1:0]  r_m, n_m;        // -d, magnitude
    logic                       r_pos, n_pos;    // d > 0
    logic                       r_quiet, n_quiet;
    logic [41:0]                r_prod, n_prod;
    logic signed [15:0]         r_level, n_level;
    logic [3:0]                 r_vu, n_vu;
    logic                       r_oval, n_oval;

    // Sample squarer for accumulation.
    logic signed [rdb_pkg::SAMPLE_W-1:0] w_s;
    logic [rdb_pkg::SQ_W-1:0]            w_sq;
    assign w_s  = w_sample_word[31:8];
    assign w_sq = rdb_pkg::SQ_W'(w_s) * rdb_pkg::SQ_W'(w_s);

    // Shared squarer for the log iterations.
    logic [61:0] w_xx;
    logic [31:0] w_xs;
    assign w_xx = r_x * r_x;
    assign w_xs = w_xx[61:30];

    // Normalize: top-bit search over the operand (sum or count).
    logic [SUM_W-1:0]           w_nv;
    logic [5:0]                 w_np;
    logic [rdb_pkg::MANT_W-1:0] w_nx;
    always_comb begin
        w_nv = (r_state == rdb_pkg::ST_LOG_SUM_NORM) ? r_sum : SUM_W'(r_cnt);
        w_np = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (w_nv[i]) w_np = 6'(i);
        end
        if (w_np >= 6'd30) w_nx = rdb_pkg::MANT_W'(w_nv >> (w_np - 6'd30));
        else               w_nx = rdb_pkg::MANT_W'(w_nv << (6'd30 - w_np));
    end

    logic [rdb_pkg::LOG_W-1:0] w_log;
    assign w_log = {r_p, r_frac};

    // Hand the result over when the output register is free or being emptied.
    logic w_load;
    assign w_load = (r_state == rdb_pkg::ST_OUT) && (!r_oval || o_out.ready);

    logic signed [rdb_pkg::LOG_W+2:0] w_d;
    logic signed [16:0]               w_lv;
    logic [15:0]                      w_vq;

    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_p     = r_p;
        n_frac  = r_frac;
        n_step  = r_step;
        n_lsum  = r_lsum;
        n_m     = r_m;
        n_pos   = r_pos;
        n_quiet = r_quiet;
        n_prod  = r_prod;
        n_level = r_level;
        n_vu    = r_vu;
        n_oval  = r_oval;
        w_d     = '0;
        w_lv    = '0;
        w_vq    = '0;

        if (o_out.ready) n_oval = 1'b0;

        unique case (r_state)
            rdb_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    // Accumulate; close the block on flag or at the limit.
                    n_sum = r_sum + SUM_W'(w_sq);
                    n_cnt = r_cnt + CNT_W'(1);
                    if (w_last_in_block || (n_cnt >= CNT_W'(BLOCK_MAX))) begin
                        n_quiet = ({n_sum, 2'b00} <= (SUM_W + 2)'(n_cnt));
                        n_state = rdb_pkg::ST_LOG_SUM_NORM;
                    end
                end
            end
            rdb_pkg::ST_LOG_SUM_NORM, rdb_pkg::ST_LOG_CNT_NORM: begin
                n_p    = w_np;
                n_x    = w_nx;
                n_frac = '0;
                n_step = '0;
                n_state = (r_state == rdb_pkg::ST_LOG_SUM_NORM) ? rdb_pkg::ST_LOG_SUM_SQ
                                                                : rdb_pkg::ST_LOG_CNT_SQ;
            end
            rdb_pkg::ST_LOG_SUM_SQ, rdb_pkg::ST_LOG_CNT_SQ: begin
                // One fraction bit per squaring.
                if (w_xs[31]) begin
                    n_x    = w_xs[31:1];
                    n_frac = {r_frac[14:0], 1'b1};
                end else begin
                    n_x    = w_xs[30:0];
                    n_frac = {r_frac[14:0], 1'b0};
                end
                n_step = r_step + 5'd1;
                if (r_step == 5'd15) begin
                    n_state = (r_state == rdb_pkg::ST_LOG_SUM_SQ) ? rdb_pkg::ST_LOG_CNT_NORM
                                                                  : rdb_pkg::ST_SCALE;
                end
                if (r_state == rdb_pkg::ST_LOG_SUM_SQ) n_lsum = {r_p, n_frac};
            end
            rdb_pkg::ST_SCALE: begin
                // d = log2(sum) - log2(count) - 2*log2(full scale)
                w_d = $signed({3'b000, r_lsum}) - $signed({3'b000, w_log})
                    - $signed({2'b00, rdb_pkg::FS_LOG2X2_Q16});
                n_pos = (w_d > 0);
                n_m   = (rdb_pkg::LOG_W + 2)'(-w_d);
                n_state = rdb_pkg::ST_LEVEL;
            end
            rdb_pkg::ST_LEVEL: begin
                if (r_step == 5'd16) begin
                    n_prod = 42'(r_m) * 42'(rdb_pkg::DB_PER_LOG2_Q16) + 42'(1 << 23);
                    n_step = '0;
                end else begin
                    if (r_quiet)                 n_level = rdb_pkg::FLOOR_Q8;
                    else if (r_pos)              n_level = '0;
                    else if (r_prod[41:24] > 18'd23040) n_level = rdb_pkg::FLOOR_Q8;
                    else n_level = -$signed(16'(r_prod[41:24]));
                    n_state = rdb_pkg::ST_VU;
                end
            end
            rdb_pkg::ST_VU: begin
                w_lv = 17'(r_level) - 17'(rdb_pkg::VU_LOW_Q8) + 17'sd640;
                // /1280 = >>8 then /5, the /5 as *205 >> 10
                w_vq = 16'(w_lv[15:8]) * 16'd205;
                if (r_level <= rdb_pkg::VU_LOW_Q8)       n_vu = 4'd0;
                else if (r_level >= rdb_pkg::VU_HIGH_Q8) n_vu = 4'd10;
                else n_vu = 4'(w_vq[15:10]);
                n_state = rdb_pkg::ST_OUT;
            end
            rdb_pkg::ST_OUT: begin
                if (w_load) begin
                    n_oval  = 1'b1;
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_state = rdb_pkg::ST_IDLE;
                end
            end
            default: n_state = rdb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdb_pkg::ST_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_oval  <= n_oval;
            r_step  <= n_step;
        end
    end

    // Datapath registers, and the output register loaded at hand-over.
    logic signed [15:0] r_out_level;
    logic [3:0]         r_out_vu;
    logic [10:0]        r_nout;
    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_p     <= n_p;
        r_frac  <= n_frac;
        r_lsum  <= n_lsum;
        r_m     <= n_m;
        r_pos   <= n_pos;
        r_quiet <= n_quiet;
        r_prod  <= n_prod;
        r_level <= n_level;
        r_vu    <= n_vu;
        if (w_load) begin
            r_out_level <= r_level;
            r_out_vu    <= r_vu;
            r_nout      <= 11'(r_cnt);
        end
    end

    assign i_in.ready                  = (r_state == rdb_pkg::ST_IDLE);
    assign o_out.valid                 = r_oval;
    assign o_out.payload.level_dbfs    = r_out_level;
    assign o_out.payload.vu_level      = r_out_vu;
    assign o_out.payload.blk_len       = r_nout;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the RMS dBFS level meter core.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        rdb_pkg::t_sample_req req;
        bit                   drain_first;   // hold this request until all levels are back
    } t_pending;

    localparam int unsigned BLOCK_LEN_MAX = 1024;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned TAIL_CYCLES   = 80;
    localparam int unsigned LONG_HOLD     = 400;

    logic i_clk;
    logic i_rst_n;

    rdb_if #(.t_payload(rdb_pkg::t_sample_req)) req_ch ();
    rdb_if #(.t_payload(rdb_pkg::t_level_rsp))  rsp_ch ();

    block_rms_dbfs_level_meter_core #(
        .BLOCK_MAX(BLOCK_LEN_MAX)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (rsp_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_pending             sample_queue[$];
    rdb_pkg::t_level_rsp  level_queue[$];
    logic [63:0] sq_sum;
    int unsigned sample_cnt;
    int unsigned fail_count;
    int unsigned level_count;
    int unsigned req_count;
    int unsigned cycle_count;
    bit          rx_long_hold;
    bit          rx_long_req;

    // log2 in Q16: integer part is the top set bit, fraction by repeated squaring
    function automatic logic [31:0] log2_fix(logic [63:0] v);
        int unsigned p;
        logic [63:0] x;
        logic [31:0] frac;
        p = 0;
        frac = '0;
        if (v == 0) return '0;
        while (p < 63 && (v >> (p + 1)) != 0) p++;
        x = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return (32'(p) << 16) | frac;
    endfunction

    // Accumulate one sample; on block close queue the expected level.
    task automatic accumulate_sample(rdb_pkg::t_sample_req r);
        logic signed [23:0]  s;
        logic signed [63:0]  d;
        logic [63:0]         m;
        logic [63:0]         q;
        int                  level;
        int unsigned         vu;
        rdb_pkg::t_level_rsp rsp;
        s = r.sample_word[31:8];
        sq_sum += 64'(longint'(s) * longint'(s));
        sample_cnt++;
        if (!r.last_in_block && sample_cnt < BLOCK_LEN_MAX) return;
        if (sq_sum * 4 <= 64'(sample_cnt)) begin
            level = rdb_pkg::FLOOR_Q8;
        end else begin
            d = $signed({32'd0, log2_fix(sq_sum)}) - $signed({32'd0, log2_fix(64'(sample_cnt))})
                - 2 * $signed({32'd0, log2_fix(64'd8388607)});
            if (d > 0) begin
                level = 0;
            end else begin
                m = -d;
                q = (m * 64'd197283 + (64'd1 << 23)) >> 24;
                level = (q > 64'd23040) ? rdb_pkg::FLOOR_Q8 : -int'(q);
            end
        end
        if (level <= rdb_pkg::VU_LOW_Q8) vu = 0;
        else if (level >= rdb_pkg::VU_HIGH_Q8) vu = 10;
        else vu = (level - rdb_pkg::VU_LOW_Q8 + 640) / 1280;
        rsp.level_dbfs = 16'(level);
        rsp.vu_level   = 4'(vu);
        rsp.blk_len    = 11'(sample_cnt);
        level_queue.push_back(rsp);
        sq_sum = '0;
        sample_cnt = 0;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Driver: offer queued requests with a random gap drawn per request.
    int unsigned tx_gap;
    bit          tx_burst;
    always @(posedge i_clk) begin
        bit nxt_valid;
        t_pending p;
        if (!i_rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
            tx_gap = 0;
            tx_burst = 1'b0;
        end else begin
            nxt_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                accumulate_sample(req_ch.payload);
                req_count++;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 18);
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (sample_queue.size() != 0 &&
                             (!sample_queue[0].drain_first || level_queue.size() == 0)) begin
                    p = sample_queue.pop_front();
                    req_ch.payload <= p.req;
                    nxt_valid = 1'b1;
                end
            end
            req_ch.valid <= nxt_valid;
        end
    end

    // Long receiver hold-off, counted here while the sender keeps going.
    int unsigned hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_long_hold <= 1'b0;
            hold_left = 0;
        end else if (rx_long_req && !rx_long_hold && hold_left == 0) begin
            rx_long_hold <= 1'b1;
            hold_left = LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) rx_long_hold <= 1'b0;
        end
    end

    // Monitor: take levels after a random stall and check them in order.
    int unsigned rx_gap;
    always @(posedge i_clk) begin
        rdb_pkg::t_level_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                level_count++;
                if (level_queue.size() == 0) begin
                    $display("[%0t] level result with none expected", $time);
                    fail_count++;
                end else begin
                    want = level_queue.pop_front();
                    if (rsp_ch.payload.level_dbfs !== want.level_dbfs)
                        report_mismatch("level_dbfs", rsp_ch.payload.level_dbfs,
                                        want.level_dbfs);
                    if (rsp_ch.payload.vu_level !== want.vu_level)
                        report_mismatch("vu_level", rsp_ch.payload.vu_level, want.vu_level);
                    if (rsp_ch.payload.blk_len !== want.blk_len)
                        report_mismatch("blk_len", rsp_ch.payload.blk_len, want.blk_len);
                end
                rx_gap = tx_burst ? 0 : $urandom_range(0, 18);
            end
            if (rx_gap > 0) rx_gap--;
            rsp_ch.ready <= (rx_gap == 0) && !rx_long_hold;
        end
    end

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_sample(logic [31:0] w, bit last, bit drain = 1'b0);
        t_pending p;
        p.req.sample_word   = w;
        p.req.last_in_block = last;
        p.drain_first       = drain;
        sample_queue.push_back(p);
    endtask

    // Random sample word drawn from one of several amplitude classes.
    function automatic logic [31:0] rand_word();
        logic signed [31:0] a;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000, 8'($urandom)};
            2: begin
                a = $signed(32'($urandom_range(0, 64))) - 32;
                return {a[23:0], 8'($urandom)};
            end
            3: begin
                a = $signed($urandom) >>> $urandom_range(8, 30);
                return {a[23:0], 8'($urandom)};
            end
            default: return $urandom_range(0, 1) ? 32'h7FFFFF00 : 32'h80000000;
        endcase
    endfunction

    initial begin
        int unsigned len;
        int unsigned total;
        i_rst_n = 1'b0;
        sq_sum = '0;
        sample_cnt = 0;
        fail_count = 0;
        level_count = 0;
        req_count = 0;
        cycle_count = 0;
        rx_long_req = 1'b0;

        // Directed: extremes, quiet blocks and full-scale blocks.
        add_sample(32'h00000000, 1'b1);                 // silent single sample
        add_sample(32'h000000FF, 1'b0);                 // only low junk bits
        add_sample(32'hFFFFFFFF, 1'b1);                 // quiet: -1 LSB, mean 0.5
        add_sample(32'hFFFFFF00, 1'b0);                 // four tiny ones, mean 0.5
        add_sample(32'h00000000, 1'b0);
        add_sample(32'h00000000, 1'b0);
        add_sample(32'h00000100, 1'b1);
        add_sample(32'h7FFFFFFF, 1'b1);                 // positive full scale
        add_sample(32'h80000000, 1'b1);                 // negative full scale, above 0 dB
        add_sample(32'h7FFFFF00, 1'b0);
        add_sample(32'h80000100, 1'b1);
        add_sample(32'h00080000, 1'b1);                 // near -72 dB
        add_sample(32'h00008000, 1'b1);                 // near -96 dB, below the floor
        add_sample(32'h00010000, 1'b1);
        add_sample(32'h00400000, 1'b1);                 // near -54 dB
        add_sample(32'h00280000, 1'b1);                 // near -58 dB
        add_sample(32'h00000200, 1'b1, 1'b1);           // below floor, after a drain
        add_sample(32'h55555555, 1'b0);
        add_sample(32'hAAAAAAAA, 1'b1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One block that closes by count alone.
        for (int i = 0; i < BLOCK_LEN_MAX; i++) add_sample(rand_word(), 1'b0);

        // Random blocks, mostly short, with the occasional drain barrier.
        total = 0;
        while (total < 300) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
                add_sample(rand_word(), i == len - 1,
                           i == 0 && $urandom_range(0, 14) == 0);
            total += len;
        end

        // Hold the receiver off once the random part is under way.
        wait (req_count > 1100);
        rx_long_req = 1'b1;
        wait (rx_long_hold);
        rx_long_req = 1'b0;

        while (sample_queue.size() != 0 || req_ch.valid || level_queue.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples and checked %0d block levels in %0d cycles.",
                 req_count, level_count, cycle_count);
        $display("Included quiet, full-scale, count-closed and stalled blocks.");
        if (fail_count == 0 && level_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
